FILE: design/jsu_pkg.sv
// Shared types, character constants and decode functions for the JSON string unescaper.
// Used by the front, queue, back and top-level modules; depends on nothing else.
`default_nettype none
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_WAIT = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_DONE = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_QUOTE  = 3'd1,
    ERR_ESCAPE = 3'd2,
    ERR_HEX    = 3'd3,
    ERR_END    = 3'd4
  } err_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // One queued request: up to three result bytes produced by one input byte.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    kind_t      kind;
    err_t       err;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // Returns {valid, nibble}.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Returns {valid, byte} for the simple escapes.
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_QUOTE:  r = {1'b1, CH_QUOTE};
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      CH_SLASH:  r = {1'b1, CH_SLASH};
      CH_LOW_B:  r = {1'b1, CH_BS};
      CH_LOW_F:  r = {1'b1, CH_FF};
      CH_LOW_N:  r = {1'b1, CH_LF};
      CH_LOW_R:  r = {1'b1, CH_CR};
      CH_LOW_T:  r = {1'b1, CH_TAB};
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic entry_t utf8_encode(input logic [15:0] v);
    entry_t e;
    e      = '0;
    e.kind = KIND_DATA;
    e.err  = ERR_NONE;
    if (v <= 16'h007F) begin
      e.cnt = 2'd1;
      e.b0  = v[7:0];
    end else if (v <= 16'h07FF) begin
      e.cnt = 2'd2;
      e.b0  = {3'b110, v[10:6]};
      e.b1  = {2'b10, v[5:0]};
    end else begin
      e.cnt = 2'd3;
      e.b0  = {4'b1110, v[15:12]};
      e.b1  = {2'b10, v[11:6]};
      e.b2  = {2'b10, v[5:0]};
    end
    return e;
  endfunction

endpackage
`default_nettype wire

FILE: design/jsu_front.sv
// Front end: accepts text bytes, tracks string mode and hex escape state,
// and builds at most one request per input byte. Depends on jsu_pkg.
`default_nettype none
module jsu_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_ended,
  input  wire logic          full,
  output logic               in_ready,
  output jsu_pkg::push_t     push
);
  import jsu_pkg::*;

  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] hex_value, hex_value_next;
  entry_t      ent;
  logic        accept;
  logic        is_ws;
  logic [4:0]  hx;
  logic [8:0]  esc;
  logic [15:0] hv_shift;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign is_ws    = (in_byte == CH_SPACE) || (in_byte >= CH_TAB && in_byte <= CH_CR);
  assign hx       = hex_decode(in_byte);
  assign esc      = esc_map(in_byte);
  assign hv_shift = {hex_value[11:0], hx[3:0]};

  always_comb begin
    mode_next      = mode;
    hex_count_next = hex_count;
    hex_value_next = hex_value;
    case (mode)
      MODE_WAIT: begin
        if (in_ended) begin
          mode_next = MODE_DONE;
        end else if (in_byte == CH_QUOTE) begin
          mode_next = MODE_STR;
        end else if (!is_ws) begin
          mode_next = MODE_DONE;
        end
      end
      MODE_STR: begin
        if (in_ended || in_byte == CH_QUOTE) begin
          mode_next = MODE_DONE;
        end else if (in_byte == CH_BSLASH) begin
          mode_next = MODE_ESC;
        end
      end
      MODE_ESC: begin
        if (in_ended) begin
          mode_next = MODE_DONE;
        end else if (in_byte == CH_LOW_U) begin
          mode_next      = MODE_HEX;
          hex_count_next = 2'd0;
          hex_value_next = 16'd0;
        end else if (esc[8]) begin
          mode_next = MODE_STR;
        end else begin
          mode_next = MODE_DONE;
        end
      end
      MODE_HEX: begin
        if (in_ended || !hx[4]) begin
          mode_next = MODE_DONE;
        end else begin
          hex_value_next = hv_shift;
          hex_count_next = hex_count + 2'd1;
          if (hex_count == 2'd3) begin
            mode_next = MODE_STR;
          end
        end
      end
      default: mode_next = mode;
    endcase
  end

  always_comb begin
    ent      = '0;
    ent.kind = KIND_DATA;
    ent.err  = ERR_NONE;
    case (mode)
      MODE_WAIT: begin
        if (in_ended || (!is_ws && in_byte != CH_QUOTE)) begin
          ent.cnt  = 2'd1;
          ent.kind = KIND_ERROR;
          ent.err  = ERR_QUOTE;
        end
      end
      MODE_STR: begin
        if (in_ended) begin
          ent.cnt  = 2'd1;
          ent.kind = KIND_ERROR;
          ent.err  = ERR_END;
        end else if (in_byte == CH_QUOTE) begin
          ent.cnt  = 2'd1;
          ent.kind = KIND_CLOSE;
        end else if (in_byte != CH_BSLASH) begin
          ent.cnt = 2'd1;
          ent.b0  = in_byte;
        end
      end
      MODE_ESC: begin
        if (in_ended) begin
          ent.cnt  = 2'd1;
          ent.kind = KIND_ERROR;
          ent.err  = ERR_END;
        end else if (esc[8]) begin
          ent.cnt = 2'd1;
          ent.b0  = esc[7:0];
        end else if (in_byte != CH_LOW_U) begin
          ent.cnt  = 2'd1;
          ent.kind = KIND_ERROR;
          ent.err  = ERR_ESCAPE;
        end
      end
      MODE_HEX: begin
        if (in_ended) begin
          ent.cnt  = 2'd1;
          ent.kind = KIND_ERROR;
          ent.err  = ERR_END;
        end else if (!hx[4]) begin
          ent.cnt  = 2'd1;
          ent.kind = KIND_ERROR;
          ent.err  = ERR_HEX;
        end else if (hex_count == 2'd3) begin
          ent = utf8_encode(hv_shift);
        end
      end
      default: ent.cnt = 2'd0;
    endcase
  end

  assign push.valid = accept && (ent.cnt != 2'd0);
  assign push.entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_WAIT;
      hex_count <= 2'd0;
      hex_value <= 16'd0;
    end else if (accept) begin
      mode      <= mode_next;
      hex_count <= hex_count_next;
      hex_value <= hex_value_next;
    end
  end

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_DONE) |=> (mode == MODE_DONE))
    else $error("finished mode was left without reset");

  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (in_valid && !full))
    else $error("request pushed without an accepted byte");

endmodule
`default_nettype wire

FILE: design/jsu_queue.sv
// Short request queue between front and back ends, register based.
// Depends on jsu_pkg for the entry and push types.
`default_nettype none
module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire jsu_pkg::push_t  push,
  input  wire logic            pop,
  output logic                 full,
  output logic                 head_valid,
  output jsu_pkg::entry_t      head
);
  import jsu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        store [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = store[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && full))
    else $error("request pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

FILE: design/jsu_back.sv
// Back end: drains queued requests onto the result stream, one byte per beat,
// marking the final result of each request. Depends on jsu_pkg.
`default_nettype none
module jsu_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire jsu_pkg::entry_t  head,
  output logic                  pop,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [15:0]           m_tdata,
  output logic [1:0]            m_tuser,
  output logic                  m_tlast
);
  import jsu_pkg::*;

  logic [1:0] idx;
  logic [7:0] sel_byte;
  logic       fire;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.b0;
      2'd1:    sel_byte = head.b1;
      default: sel_byte = head.b2;
    endcase
  end

  assign m_tvalid = head_valid;
  assign m_tdata  = {5'd0, head.err, sel_byte};
  assign m_tuser  = head.kind;
  assign m_tlast  = (idx == head.cnt - 2'd1);
  assign fire     = m_tvalid && m_tready;
  assign pop      = fire && m_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (pop) begin
      idx <= 2'd0;
    end else if (fire) begin
      idx <= idx + 2'd1;
    end
  end

  a_idx_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(idx))
    else $error("result index moved during a stall");

endmodule
`default_nettype wire

FILE: design/json_string_unescape_utf8.sv
// The request built from an accepted input byte is registered in the request queue
// before its first result is offered. Throughput: one input byte per cycle while the
// request queue has room; results leave at one per cycle while m_tready is high, so a
// \u escape of three bytes holds the output until all are taken. Queue depth QUEUE_DEPTH
// sets how long the input side runs ahead of a stalled output. Reset (rst, synchronous,
// active high) returns to waiting for the opening quote and empties the queue.
`default_nettype none
module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic [0:0]  s_tuser,   // [0] input_ended
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
  output logic [1:0]       m_tuser,   // [1:0] kind
  output logic             m_tlast
);
  import jsu_pkg::*;

  push_t  push;
  entry_t head;
  logic   full, head_valid, pop;

  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_ended (s_tuser[0]),
    .full     (full),
    .in_ready (s_tready),
    .push     (push)
  );

  jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
`default_nettype wire
